@@ rtl/scwp_pkg.sv @@
// Shared types, constants and the identity reply ROM for the serial command
// window parser. No dependencies.
`default_nettype none

package scwp_pkg;

   localparam int WINDOW_LENGTH = 7;
   localparam int KEPT_LENGTH   = WINDOW_LENGTH - 1;
   localparam int REPLY_LENGTH  = 32;
   localparam int REPLY_CNT_W   = $clog2(REPLY_LENGTH);
   localparam int VALUE_COUNT   = 5;
   localparam int VAL_IDX_W     = $clog2(VALUE_COUNT);
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] NO_DATA  = 8'hFF;
   localparam logic [7:0] FIRST_ID = 8'h64;
   localparam logic [7:0] LAST_ID  = 8'h68;

   localparam logic [0:WINDOW_LENGTH-1][7:0] DEVICE_WORD = "/device";
   localparam logic [0:3][7:0]               REG_WORD    = "/reg";

   // One classified word handed from front to back.
   typedef struct packed {
      logic                            is_reply;
      logic [VALUE_COUNT-1:0][7:0]     values;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [7:0] reply_rom(input logic [REPLY_CNT_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:  b = 8'h01;
         5'd1:  b = 8'h1C;
         5'd2:  b = 8'h40;
         5'd3:  b = 8'h00;
         5'd4:  b = 8'h19;
         5'd5:  b = 8'h3C;
         5'd6:  b = 8'h44;
         5'd7:  b = 8'h45;
         5'd8:  b = 8'h56;
         5'd9:  b = 8'h49;
         5'd10: b = 8'h43;
         5'd11: b = 8'h45;
         5'd12: b = 8'h3E;
         5'd13: b = 8'h52;
         5'd14: b = 8'h4F;
         5'd15: b = 8'h42;
         5'd16: b = 8'h4F;
         5'd17: b = 8'h54;
         5'd18: b = 8'h3C;
         5'd19: b = 8'h2F;
         5'd20: b = 8'h44;
         5'd21: b = 8'h45;
         5'd22: b = 8'h56;
         5'd23: b = 8'h49;
         5'd24: b = 8'h43;
         5'd25: b = 8'h45;
         5'd26: b = 8'h3E;
         5'd27: b = 8'h0D;
         5'd28: b = 8'h0A;
         5'd29: b = 8'h0D;
         5'd30: b = 8'hC7;
         5'd31: b = 8'h1E;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

@@ rtl/scwp_front.sv @@
// Front end: byte window, pattern match and value registers.
// Depends on scwp_pkg.
`default_nettype none

module scwp_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_rx_byte,
   input  wire scwp_pkg::q_status_type q_status,
   output logic                        push,
   output scwp_pkg::cmd_type           push_cmd
);

   logic [scwp_pkg::KEPT_LENGTH-1:0][7:0] win_ff, win_in;
   logic [scwp_pkg::VALUE_COUNT-1:0][7:0] vals_ff, vals_in;
   logic                                  accept, no_data, is_reg, is_device, id_ok;
   logic [7:0]                            id_off;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign no_data   = (req_rx_byte == scwp_pkg::NO_DATA);

   always_comb begin
      is_reg = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (win_ff[1 + i] != scwp_pkg::REG_WORD[i]) is_reg = 1'b0;
      end
      is_device = (req_rx_byte == scwp_pkg::DEVICE_WORD[scwp_pkg::WINDOW_LENGTH-1]);
      for (int i = 0; i < scwp_pkg::KEPT_LENGTH; i++) begin
         if (win_ff[i] != scwp_pkg::DEVICE_WORD[i]) is_device = 1'b0;
      end
   end

   assign id_ok  = (win_ff[5] >= scwp_pkg::FIRST_ID) && (win_ff[5] <= scwp_pkg::LAST_ID);
   assign id_off = win_ff[5] - scwp_pkg::FIRST_ID;

   always_comb begin
      vals_in = vals_ff;
      win_in  = win_ff;
      if (!no_data) begin
         if (is_reg && id_ok) vals_in[id_off[scwp_pkg::VAL_IDX_W-1:0]] = req_rx_byte;
         for (int i = 0; i < scwp_pkg::KEPT_LENGTH - 1; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[scwp_pkg::KEPT_LENGTH-1] = req_rx_byte;
      end
   end

   assign push              = accept;
   assign push_cmd.is_reply = !no_data && is_device;
   assign push_cmd.values   = vals_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         vals_ff <= '0;
      end else if (accept) begin
         win_ff  <= win_in;
         vals_ff <= vals_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/scwp_queue.sv @@
// Small command queue between front and back.
// Depends on scwp_pkg.
`default_nettype none

module scwp_queue #(
   parameter int QUEUE_DEPTH = scwp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire scwp_pkg::cmd_type push_cmd,
   input  wire logic              pop,
   output scwp_pkg::cmd_type      head_cmd,
   output scwp_pkg::q_status_type q_status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   scwp_pkg::cmd_type mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign head_cmd       = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !push || pop)
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue underflow");

endmodule

`default_nettype wire

@@ rtl/scwp_back.sv @@
// Back end: turns queued commands into status words or the 32-word reply run.
// Depends on scwp_pkg.
`default_nettype none

module scwp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire scwp_pkg::cmd_type      head_cmd,
   input  wire scwp_pkg::q_status_type q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic                        rsp_reply_valid,
   output logic [7:0]                  rsp_reply_byte,
   output logic                        rsp_run_last,
   output logic [scwp_pkg::VALUE_COUNT-1:0][7:0] rsp_values
);

   localparam logic [scwp_pkg::REPLY_CNT_W-1:0] CNT_LAST =
      scwp_pkg::REPLY_CNT_W'(scwp_pkg::REPLY_LENGTH - 1);

   logic                                  valid_ff;
   logic                                  reply_valid_ff, run_last_ff;
   logic [7:0]                            reply_byte_ff;
   logic [scwp_pkg::VALUE_COUNT-1:0][7:0] values_ff;
   logic [scwp_pkg::REPLY_CNT_W-1:0]      cnt_ff, cnt_in;
   logic                                  out_free, load, last_word;

   assign out_free  = !valid_ff || !rsp_stall;
   assign load      = out_free && !q_status.empty;
   assign last_word = !head_cmd.is_reply || (cnt_ff == CNT_LAST);
   assign pop       = load && last_word;

   always_comb begin
      cnt_in = cnt_ff;
      if (load && head_cmd.is_reply) cnt_in = last_word ? '0 : cnt_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (out_free) valid_ff <= !q_status.empty;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         reply_valid_ff <= head_cmd.is_reply;
         reply_byte_ff  <= head_cmd.is_reply ? scwp_pkg::reply_rom(cnt_ff) : 8'h00;
         run_last_ff    <= last_word;
         values_ff      <= head_cmd.values;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_reply_valid = reply_valid_ff;
   assign rsp_reply_byte  = reply_byte_ff;
   assign rsp_run_last    = run_last_ff;
   assign rsp_values      = values_ff;

   a_run_needs_head: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> !q_status.empty)
      else $error("reply run without queued command");
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !reply_valid_ff) |-> (run_last_ff && reply_byte_ff == 8'h00))
      else $error("bad status word");

endmodule

`default_nettype wire

@@ rtl/serial_command_window_parser.sv @@
// Top level of the serial command window parser: front, queue and back.
// Depends on scwp_pkg, scwp_front, scwp_queue, scwp_back.
//
//   channel   dir   handshake             payload
//   req       in    req_valid/req_stall   req_rx_byte
//   rsp       out   rsp_valid/rsp_stall   reply_valid, reply_byte, run_last, value_id_100..104
//
// Flow: the front takes one byte per cycle while req_stall is low; each byte is matched
// and queued in the cycle it is accepted. A plain byte gives one status word through the
// queue and output register; a completed "/device" gives 32 words, one per cycle while
// rsp_stall is low, read from the reply ROM by the back end's word counter.
// Stalls: req_stall rises only while the QUEUE_DEPTH-entry queue is full,
// which a reply run can cause. rsp_stall holds the output register.
// Reset clears the window, the value registers, the queue and the output.
`default_nettype none

module serial_command_window_parser #(
   parameter int QUEUE_DEPTH = scwp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_reply_valid,
   output logic [7:0]      rsp_reply_byte,
   output logic            rsp_run_last,
   output logic [7:0]      rsp_value_id_100,
   output logic [7:0]      rsp_value_id_101,
   output logic [7:0]      rsp_value_id_102,
   output logic [7:0]      rsp_value_id_103,
   output logic [7:0]      rsp_value_id_104
);

   scwp_pkg::q_status_type                q_status;
   scwp_pkg::cmd_type                     push_cmd, head_cmd;
   logic                                  push, pop;
   logic [scwp_pkg::VALUE_COUNT-1:0][7:0] values;

   // Front: window shift, "/reg" store and "/device" detect.
   scwp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Queue decouples matching from the long reply run.
   scwp_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_status (q_status)
   );

   // Back: one status word or the ROM run per queued command.
   scwp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .q_status        (q_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_reply_valid (rsp_reply_valid),
      .rsp_reply_byte  (rsp_reply_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_values      (values)
   );

   assign rsp_value_id_100 = values[0];
   assign rsp_value_id_101 = values[1];
   assign rsp_value_id_102 = values[2];
   assign rsp_value_id_103 = values[3];
   assign rsp_value_id_104 = values[4];

endmodule

`default_nettype wire

@@ bench/tb_serial_command_window_parser.sv @@
// Self-checking bench for serial_command_window_parser: byte stream in, reply
// and status words out, each compared with a behavioral prediction.
// Depends on the RTL in rtl/ (scwp_pkg and the parser top level).
`default_nettype none

module tb_serial_command_window_parser;
   timeunit 1ns;
   timeprecision 1ps;

   // ---------------------------------------------------------------------
   // Local constants for the prediction.
   // ---------------------------------------------------------------------
   localparam logic [7:0] NO_DATA_BYTE = 8'hFF;
   localparam logic [7:0] ID_FIRST     = 8'h64;
   localparam logic [7:0] ID_LAST      = 8'h68;
   localparam int         KEPT_BYTES   = 6;
   localparam int         NUM_VALUES   = 5;
   localparam int         REPLY_WORDS  = 32;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         LONG_HOLD    = 250;

   localparam logic [0:6][7:0] DEVICE_TEXT = "/device";
   localparam logic [0:3][7:0] REG_TEXT    = "/reg";

   // identity reply, sent in this order, last byte flagged
   localparam logic [7:0] ID_REPLY [REPLY_WORDS] = '{
      8'h01, 8'h1C, 8'h40, 8'h00, 8'h19, 8'h3C, 8'h44, 8'h45,
      8'h56, 8'h49, 8'h43, 8'h45, 8'h3E, 8'h52, 8'h4F, 8'h42,
      8'h4F, 8'h54, 8'h3C, 8'h2F, 8'h44, 8'h45, 8'h56, 8'h49,
      8'h43, 8'h45, 8'h3E, 8'h0D, 8'h0A, 8'h0D, 8'hC7, 8'h1E
   };

   typedef enum int {SEQ_REG_WRITE, SEQ_DEVICE, SEQ_BROKEN, SEQ_NOISE} seq_kind_type;

   // one output word as the parser should present it
   typedef struct packed {
      logic                         reply_valid;
      logic [7:0]                   reply_byte;
      logic                         run_last;
      logic [NUM_VALUES-1:0][7:0]   vals;      // vals[0] is id 0x64
   } parser_word_type;

   // ---------------------------------------------------------------------
   // DUT hookup. Every input has a known value from time zero.
   // ---------------------------------------------------------------------
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_stall   = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_reply_valid;
   logic [7:0] rsp_reply_byte;
   logic       rsp_run_last;
   logic [7:0] rsp_value_id_100;
   logic [7:0] rsp_value_id_101;
   logic [7:0] rsp_value_id_102;
   logic [7:0] rsp_value_id_103;
   logic [7:0] rsp_value_id_104;

   serial_command_window_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_reply_valid  (rsp_reply_valid),
      .rsp_reply_byte   (rsp_reply_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_value_id_100 (rsp_value_id_100),
      .rsp_value_id_101 (rsp_value_id_101),
      .rsp_value_id_102 (rsp_value_id_102),
      .rsp_value_id_103 (rsp_value_id_103),
      .rsp_value_id_104 (rsp_value_id_104)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor state: shadow copy of the byte window and value registers,
   // plus the queue of words still owed by the DUT.
   // ---------------------------------------------------------------------
   logic [7:0]      rx_window  [KEPT_BYTES];   // oldest first
   logic [7:0]      value_regs [NUM_VALUES];
   parser_word_type pending_words [$];
   int              fail_count    = 0;
   int              bytes_sent    = 0;

   // sender pacing and receiver hold-off knobs
   int              burst_left    = 0;
   bit              gaps_on       = 1'b1;
   int              hold_request  = 0;

   function automatic parser_word_type status_word(input logic valid, input logic [7:0] b,
                                                   input logic last);
      parser_word_type w;
      w.reply_valid = valid;
      w.reply_byte  = b;
      w.run_last    = last;
      for (int k = 0; k < NUM_VALUES; k++) w.vals[k] = value_regs[k];
      return w;
   endfunction

   // Work out what one accepted byte produces and queue it.
   function automatic void predict_words(input logic [7:0] rx);
      logic [7:0] win [KEPT_BYTES+1];
      logic       reg_hit;
      logic       dev_hit;
      // no-data marker: state untouched, one plain status word
      if (rx == NO_DATA_BYTE) begin
         pending_words.push_back(status_word(1'b0, 8'h00, 1'b1));
         return;
      end
      for (int k = 0; k < KEPT_BYTES; k++) win[k] = rx_window[k];
      win[KEPT_BYTES] = rx;

      // "/reg" in positions 1..4, id in 5, newest byte is the value
      reg_hit = 1'b1;
      for (int k = 0; k < 4; k++) if (win[1+k] != REG_TEXT[k]) reg_hit = 1'b0;
      if (reg_hit && win[5] >= ID_FIRST && win[5] <= ID_LAST)
         value_regs[3'(win[5] - ID_FIRST)] = rx;

      dev_hit = 1'b1;
      for (int k = 0; k <= KEPT_BYTES; k++) if (win[k] != DEVICE_TEXT[k]) dev_hit = 1'b0;

      for (int k = 0; k < KEPT_BYTES; k++) rx_window[k] = win[k+1];

      if (dev_hit) begin
         for (int k = 0; k < REPLY_WORDS; k++)
            pending_words.push_back(status_word(1'b1, ID_REPLY[k], k == REPLY_WORDS-1));
      end else begin
         pending_words.push_back(status_word(1'b0, 8'h00, 1'b1));
      end
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every accepted output word against the oldest
   // prediction. Keeps running after a mismatch.
   // ---------------------------------------------------------------------
   function automatic void check_field(input string what, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $display("%0t ns: %s mismatch: expected %02h, got %02h", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : word_checker
      parser_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_words.size() == 0) begin
            $display("%0t ns: unexpected word: expected none, got reply_byte %02h",
                     $time, rsp_reply_byte);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            check_field("reply_valid",  {7'd0, want.reply_valid}, {7'd0, rsp_reply_valid});
            check_field("reply_byte",   want.reply_byte,          rsp_reply_byte);
            check_field("run_last",     {7'd0, want.run_last},    {7'd0, rsp_run_last});
            check_field("value_id_100", want.vals[0],             rsp_value_id_100);
            check_field("value_id_101", want.vals[1],             rsp_value_id_101);
            check_field("value_id_102", want.vals[2],             rsp_value_id_102);
            check_field("value_id_103", want.vals[3],             rsp_value_id_103);
            check_field("value_id_104", want.vals[4],             rsp_value_id_104);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall pattern. Picks a mode for a random span: no stall,
   // light, heavy or every other cycle. A hold request from a test forces a
   // long solid stall, counted down here.
   // ---------------------------------------------------------------------
   initial begin : rsp_stall_gen
      int mode;
      int span;
      int hold;
      mode = 0;
      span = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold         = hold_request;
            hold_request = 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            hold--;
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 120);
            end
            span--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 20);
               2: rsp_stall <= ($urandom_range(0, 99) < 70);
               default: rsp_stall <= ~rsp_stall;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender: bursts of random length, random gaps in between. Valid stays
   // high across back-to-back bytes; it is only dropped for a gap.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = 0;
         if (gaps_on) begin
            case ($urandom_range(0, 9))
               0, 1:    gap = 0;
               2:       gap = $urandom_range(5, 20);
               default: gap = $urandom_range(1, 4);
            endcase
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      predict_words(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int k = 0; k < s.len(); k++) send_byte(s[k]);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // value writes at both ends of the id range, values 0xFE and 0x01
   task automatic test_register_write();
      send_text("/reg");
      send_byte(ID_FIRST);
      send_byte(8'hFE);
      send_text("/reg");
      send_byte(ID_LAST);
      send_byte(8'h01);
   endtask

   // id just past the range must store nothing
   task automatic test_unknown_id();
      send_text("/reg");
      send_byte(ID_LAST + 8'd1);
      send_byte(8'h55);
   endtask

   // "/device" with a no-data byte in the middle still completes the match
   task automatic test_device_reply();
      send_text("/dev");
      send_byte(NO_DATA_BYTE);
      send_text("ice");
   endtask

   // receiver holds off while the sender keeps pushing replies, so the
   // internal queue fills and req_stall has to rise
   task automatic test_backpressure();
      gaps_on      = 1'b0;
      burst_left   = 0;
      hold_request = LONG_HOLD;
      repeat (3) send_text("/device");
      send_byte(8'h00);
      gaps_on = 1'b1;
   endtask

   // mostly well-formed commands with random content, some noise and
   // truncated commands
   task automatic test_random_traffic(input int num_bytes);
      int           start;
      int           pick;
      int           cut;
      seq_kind_type kind;
      string        txt;
      start = bytes_sent;
      while (bytes_sent - start < num_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 45)      kind = SEQ_REG_WRITE;
         else if (pick < 53) kind = SEQ_DEVICE;
         else if (pick < 70) kind = SEQ_BROKEN;
         else                kind = SEQ_NOISE;
         case (kind)
            SEQ_REG_WRITE: begin
               send_text("/reg");
               if ($urandom_range(0, 9) < 8) send_byte(8'($urandom_range(ID_FIRST, ID_LAST)));
               else send_byte(8'($urandom_range(ID_FIRST - 8'd2, ID_LAST + 8'd2)));
               send_byte(8'($urandom_range(0, 255)));
            end
            SEQ_DEVICE: begin
               txt = "/device";
               for (int k = 0; k < txt.len(); k++) begin
                  if ($urandom_range(0, 9) == 0) send_byte(NO_DATA_BYTE);
                  send_byte(txt[k]);
               end
            end
            SEQ_BROKEN: begin
               txt = ($urandom_range(0, 1) != 0) ? "/device" : "/reg";
               cut = $urandom_range(1, txt.len() - 1);
               for (int k = 0; k < cut; k++) send_byte(txt[k]);
               send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
               repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
            end
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      for (int k = 0; k < KEPT_BYTES; k++) rx_window[k] = 8'h00;
      for (int k = 0; k < NUM_VALUES; k++) value_regs[k] = 8'h00;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_write();
      test_unknown_id();
      test_device_reply();
      test_backpressure();
      test_random_traffic(230);

      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("** serial_command_window_parser: PASSED **");
      else
         $display("** serial_command_window_parser: FAILED **");
      $finish;
   end

   // watchdog: far beyond the slowest legal run
   initial begin : watchdog
      #3_000_000;
      $display("** serial_command_window_parser: FAILED **");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/scwp_pkg.sv
rtl/scwp_front.sv
rtl/scwp_queue.sv
rtl/scwp_back.sv
rtl/serial_command_window_parser.sv
bench/tb_serial_command_window_parser.sv
